[hw/rtl/bus_response_frame_checker_assert.svh]
// ----------------------------------------------------------------------------
// bus_response_frame_checker_assert.svh
// Assertion macros for the bus response frame checker. Simulation builds
// get concurrent assertions; synthesis builds (SYNTH) get empty bodies.
// ----------------------------------------------------------------------------
`ifndef BUS_RESPONSE_FRAME_CHECKER_ASSERT_SVH
`define BUS_RESPONSE_FRAME_CHECKER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted (active low).
`define BRFC_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define BRFC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define BRFC_ASSERT_NOW(name, clk, rst_n, ante, cons)
`define BRFC_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/brfc_pkg.sv]
// ----------------------------------------------------------------------------
// brfc_pkg
// Shared codes, types and the CRC-8 byte update for the bus response frame
// checker.
// ----------------------------------------------------------------------------
package brfc_pkg;

    // Input opcodes
    localparam logic [1:0] OP_ARM   = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_FAULT = 2'd2;

    // Response kinds; any other code is handled as raw payload
    localparam logic [1:0] KIND_REGS = 2'd0;
    localparam logic [1:0] KIND_ECHO = 2'd1;

    // Result kinds
    localparam logic [1:0] RK_WORD   = 2'd0;
    localparam logic [1:0] RK_BYTE   = 2'd1;
    localparam logic [1:0] RK_STATUS = 2'd2;

    // Final status codes; exceptions 1..4 map onto ST_CRC + exception
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_TIMEOUT   = 4'd1;
    localparam logic [3:0] ST_TRANSPORT = 4'd2;
    localparam logic [3:0] ST_BAD_UNIT  = 4'd3;
    localparam logic [3:0] ST_INVALID   = 4'd4;
    localparam logic [3:0] ST_CRC       = 4'd5;

    localparam logic [7:0] CRC_POLY     = 8'h07;
    localparam logic [1:0] ERR_CODE_RST = 2'd2;
    localparam logic [7:0] ECHO_BYTES   = 8'd4;

    typedef enum logic [8:0] {
        PH_IDLE     = 9'b000000001,
        PH_HEADER   = 9'b000000010,
        PH_EXC      = 9'b000000100,
        PH_EXC_FOOT = 9'b000001000,
        PH_COUNT    = 9'b000010000,
        PH_REGS     = 9'b000100000,
        PH_ECHO     = 9'b001000000,
        PH_RAW      = 9'b010000000,
        PH_FOOT     = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [1:0]  response_kind;
        logic [5:0]  expected_unit;
        logic [1:0]  expected_code;
        logic [15:0] expected_address;
        logic [7:0]  expected_count;
        logic [7:0]  rx_byte;
        logic        fault_kind;
    } item_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  result_kind;
        logic [15:0] data_value;
        logic [3:0]  status;
        logic        frame_done;
    } result_t;

    // CRC-8, MSB first, no reflection
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
        end
        return v;
    endfunction

endpackage

[hw/rtl/bus_response_frame_checker.sv]
// An accepted item waits in the input register until the result register takes its
// result. Throughput: one item per cycle while m_ready does not stall the output; the
// per-byte CRC-8 and header checks sit in one stage between the two registers.
// Reset (aresetn low, synchronous): input and result registers empty, frame
// state idle, exception code register back to 2.
// ----------------------------------------------------------------------------
// bus_response_frame_checker
// Client-side checker for response frames of a serial bus: header, body and
// CRC-8 trailer checks, register word and raw byte delivery, final status.
// ----------------------------------------------------------------------------
`include "bus_response_frame_checker_assert.svh"

module bus_response_frame_checker
    import brfc_pkg::*;
#(
    parameter int MAX_DATA_BYTES = 250
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [1:0]  s_response_kind,
    input  logic [5:0]  s_expected_unit,
    input  logic [1:0]  s_expected_code,
    input  logic [15:0] s_expected_address,
    input  logic [7:0]  s_expected_count,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_fault_kind,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [15:0] m_data_value,
    output logic [3:0]  m_status,
    output logic        m_frame_done
);

    logic [1:0] error_code_reg;

    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       out_valid_reg;
    result_t    out_res_reg;

    logic       s_xfer;
    logic       advance;
    result_t    res;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_xfer  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_code_reg <= ERR_CODE_RST;
        end else if (cfg_wr_en) begin
            error_code_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_item_reg <= '{opcode:           s_opcode,
                             response_kind:    s_response_kind,
                             expected_unit:    s_expected_unit,
                             expected_code:    s_expected_code,
                             expected_address: s_expected_address,
                             expected_count:   s_expected_count,
                             rx_byte:          s_rx_byte,
                             fault_kind:       s_fault_kind};
        end
    end

    brfc_frame #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_frame (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .item       (in_item_reg),
        .error_code (error_code_reg),
        .res        (res)
    );

    // Result register: load on advance, drop once the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res.valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_result_kind = out_res_reg.result_kind;
    assign m_data_value  = out_res_reg.data_value;
    assign m_status      = out_res_reg.status;
    assign m_frame_done  = out_res_reg.frame_done;

    `BRFC_ASSERT_NOW(a_ready_when_out_empty, aclk, aresetn, !out_valid_reg, s_ready)
    `BRFC_ASSERT_NEXT(a_hold_pending_item, aclk, aresetn, in_valid_reg && !advance, in_valid_reg)
    `BRFC_ASSERT_NEXT(a_final_reaches_port, aclk, aresetn, advance && res.valid && res.frame_done, m_valid && m_frame_done && m_result_kind == RK_STATUS)
    `BRFC_ASSERT_NOW(a_data_not_done, aclk, aresetn, m_valid && m_result_kind != RK_STATUS, !m_frame_done && m_status == ST_OK)

endmodule

[hw/rtl/brfc_frame.sv]
// ----------------------------------------------------------------------------
// brfc_frame
// Frame walker: holds the expected response and the per-frame state, and
// turns one item per cycle, while step is high, into at most one result.
// ----------------------------------------------------------------------------
module brfc_frame
    import brfc_pkg::*;
#(
    parameter int MAX_DATA_BYTES = 250
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  item_t      item,
    input  logic [1:0] error_code,
    output result_t    res
);

    phase_t      phase_reg,   phase_next;
    logic [1:0]  kind_reg,    kind_next;
    logic [5:0]  unit_reg,    unit_next;
    logic [1:0]  code_reg,    code_next;
    logic [15:0] addr_reg,    addr_next;
    logic [7:0]  count_reg,   count_next;
    logic [7:0]  crc_reg,     crc_next;
    logic [7:0]  left_reg,    left_next;
    logic [7:0]  bcf_reg,     bcf_next;
    logic [7:0]  high_reg,    high_next;
    logic [15:0] echo_reg,    echo_next;
    logic [7:0]  exc_reg,     exc_next;
    logic [1:0]  pos_reg,     pos_next;

    logic [7:0]  b;
    logic [7:0]  crc_upd;
    logic [15:0] word;
    logic        fin;
    logic [3:0]  fin_status;

    assign b       = item.rx_byte;
    assign crc_upd = crc8_update(crc_reg, b);
    assign word    = {high_reg, b};

    always_comb begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        unit_next  = unit_reg;
        code_next  = code_reg;
        addr_next  = addr_reg;
        count_next = count_reg;
        crc_next   = crc_reg;
        left_next  = left_reg;
        bcf_next   = bcf_reg;
        high_next  = high_reg;
        echo_next  = echo_reg;
        exc_next   = exc_reg;
        pos_next   = pos_reg;
        res        = '0;
        fin        = 1'b0;
        fin_status = ST_OK;

        if (step) begin
            unique case (item.opcode)
                OP_ARM: begin
                    kind_next  = item.response_kind;
                    unit_next  = item.expected_unit;
                    code_next  = item.expected_code;
                    addr_next  = item.expected_address;
                    count_next = item.expected_count;
                    crc_next   = '0;
                    left_next  = '0;
                    bcf_next   = '0;
                    high_next  = '0;
                    echo_next  = '0;
                    exc_next   = '0;
                    pos_next   = '0;
                    phase_next = PH_HEADER;
                end
                OP_FAULT: begin
                    if (phase_reg != PH_IDLE) begin
                        fin        = 1'b1;
                        fin_status = item.fault_kind ? ST_TRANSPORT : ST_TIMEOUT;
                    end
                end
                OP_BYTE: begin
                    unique case (phase_reg)
                        PH_IDLE: ;
                        PH_HEADER: begin
                            crc_next = crc_upd;
                            if (b[5:0] != unit_reg) begin
                                fin        = 1'b1;
                                fin_status = ST_BAD_UNIT;
                            end else if (b[7:6] != code_reg) begin
                                if (b[7:6] == error_code) begin
                                    phase_next = PH_EXC;
                                end else begin
                                    fin        = 1'b1;
                                    fin_status = ST_INVALID;
                                end
                            end else begin
                                pos_next = '0;
                                if (kind_reg == KIND_REGS) begin
                                    phase_next = PH_COUNT;
                                end else if (kind_reg == KIND_ECHO) begin
                                    left_next  = ECHO_BYTES;
                                    phase_next = PH_ECHO;
                                end else begin
                                    left_next  = count_reg;
                                    phase_next = (count_reg == '0) ? PH_FOOT : PH_RAW;
                                end
                            end
                        end
                        PH_EXC: begin
                            crc_next   = crc_upd;
                            exc_next   = b;
                            phase_next = PH_EXC_FOOT;
                        end
                        PH_EXC_FOOT: begin
                            fin = 1'b1;
                            if (b != crc_reg) begin
                                fin_status = ST_CRC;
                            end else if (exc_reg == '0 || exc_reg > 8'd4) begin
                                fin_status = ST_INVALID;
                            end else begin
                                fin_status = ST_CRC + {1'b0, exc_reg[2:0]};
                            end
                        end
                        PH_COUNT: begin
                            crc_next = crc_upd;
                            bcf_next = b;
                            if (b > 8'(MAX_DATA_BYTES)) begin
                                fin        = 1'b1;
                                fin_status = ST_INVALID;
                            end else begin
                                left_next  = b;
                                pos_next   = '0;
                                phase_next = (b == '0) ? PH_FOOT : PH_REGS;
                            end
                        end
                        PH_REGS: begin
                            crc_next = crc_upd;
                            if (!pos_reg[0]) begin
                                high_next = b;
                            end else begin
                                res.valid       = 1'b1;
                                res.result_kind = RK_WORD;
                                res.data_value  = word;
                            end
                            pos_next  = pos_reg + 2'd1;
                            left_next = left_reg - 8'd1;
                            if (left_reg == 8'd1) begin
                                phase_next = PH_FOOT;
                            end
                        end
                        PH_ECHO: begin
                            crc_next = crc_upd;
                            unique case (pos_reg)
                                2'd0, 2'd2: high_next = b;
                                2'd1:       echo_next = word;
                                default:    bcf_next  = {7'd0, word != {8'd0, count_reg}};
                            endcase
                            pos_next  = pos_reg + 2'd1;
                            left_next = left_reg - 8'd1;
                            if (left_reg == 8'd1) begin
                                phase_next = PH_FOOT;
                            end
                        end
                        PH_RAW: begin
                            crc_next        = crc_upd;
                            left_next       = left_reg - 8'd1;
                            res.valid       = 1'b1;
                            res.result_kind = RK_BYTE;
                            res.data_value  = {8'd0, b};
                            if (left_reg == 8'd1) begin
                                phase_next = PH_FOOT;
                            end
                        end
                        PH_FOOT: begin
                            fin = 1'b1;
                            if (b != crc_reg) begin
                                fin_status = ST_CRC;
                            end else if (kind_reg == KIND_REGS &&
                                         {1'b0, bcf_reg} != {count_reg, 1'b0}) begin
                                fin_status = ST_INVALID;
                            end else if (kind_reg == KIND_ECHO &&
                                         (echo_reg != addr_reg || bcf_reg != '0)) begin
                                fin_status = ST_INVALID;
                            end else begin
                                fin_status = ST_OK;
                            end
                        end
                        default: phase_next = PH_IDLE;
                    endcase
                end
                default: ;
            endcase

            if (fin) begin
                phase_next      = PH_IDLE;
                res.valid       = 1'b1;
                res.result_kind = RK_STATUS;
                res.data_value  = '0;
                res.status      = fin_status;
                res.frame_done  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    // Frame payload state is always loaded by an arm before it is read
    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        unit_reg  <= unit_next;
        code_reg  <= code_next;
        addr_reg  <= addr_next;
        count_reg <= count_next;
        crc_reg   <= crc_next;
        left_reg  <= left_next;
        bcf_reg   <= bcf_next;
        high_reg  <= high_next;
        echo_reg  <= echo_next;
        exc_reg   <= exc_next;
        pos_reg   <= pos_next;
    end

endmodule
